@@ sv/mesh_vertex_normal_accumulate_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the vertex normal accumulator
// Shared helpers for concurrent checks, clocked on clk with active-low reset.
// ----------------------------------------------------------------------------
`ifndef MESH_VERTEX_NORMAL_ACCUMULATE_TOP_DEFINES_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATE_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MVNA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mvna check failed");

// antecedent implies consequent in the next cycle
`define MVNA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mvna check failed");

`endif

@@ sv/mvna_pkg.sv @@
// ----------------------------------------------------------------------------
// mvna_pkg
// Types and constants of the vertex normal accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mvna_pkg;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned POS_W   = 24;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned EDGE_W  = 25;
  localparam int unsigned CROSS_W = 51;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_TRI  = 2'd1,
    KIND_READ = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_CAP_C,
    ST_EDGE,
    ST_CROSS,
    ST_TUNIT,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_R_RD,
    ST_R_CAP,
    ST_RUNIT,
    ST_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_NORM,
    U_SQ,
    U_SQRT,
    U_DIV,
    U_DONE
  } unit_state_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } unit_res_t;

endpackage

`default_nettype wire

@@ sv/mvna_unit.sv @@
// ----------------------------------------------------------------------------
// mvna_unit
// Scales a 3-vector to a Q1.15 unit vector: normalize, sum of squares,
// bit-serial square root, then one restoring division per component.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvna_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [50:0]       vx,
  input  wire logic signed [50:0]       vy,
  input  wire logic signed [50:0]       vz,
  output mvna_pkg::unit_res_t           res
);

  mvna_pkg::unit_state_t state_r, state_nxt;

  logic [50:0] mag_r [3];
  logic [2:0]  neg_r;
  logic [50:0] m_r;
  logic [1:0]  cnt_r;
  logic [59:0] prod_r;
  logic [61:0] sum_r;
  logic [62:0] x_r;
  logic [62:0] res_r;
  logic [62:0] bit_r;
  logic [31:0] rem_r;
  logic [3:0]  dstep_r;
  logic [15:0] quo_r;
  logic signed [15:0] q_r [3];
  logic        done_r;

  logic [50:0] mag_in [3];
  logic [50:0] max_in;
  logic [29:0] sq_op;
  logic [62:0] trial;
  logic [30:0] len;
  logic [31:0] rem_cur;
  logic        qbit;
  logic [15:0] quo_nxt;
  logic [15:0] clamp;

  always_comb begin
    mag_in[0] = vx[50] ? 51'(-vx) : 51'(vx);
    mag_in[1] = vy[50] ? 51'(-vy) : 51'(vy);
    mag_in[2] = vz[50] ? 51'(-vz) : 51'(vz);
    max_in = mag_in[0];
    if (mag_in[1] > max_in) max_in = mag_in[1];
    if (mag_in[2] > max_in) max_in = mag_in[2];
  end

  always_comb begin
    case (cnt_r)
      2'd0:    sq_op = mag_r[0][29:0];
      2'd1:    sq_op = mag_r[1][29:0];
      default: sq_op = mag_r[2][29:0];
    endcase
  end

  assign trial = res_r + bit_r;
  assign len   = res_r[30:0];

  // first step starts from the component itself, later steps double
  assign rem_cur = (dstep_r == 4'd0) ? rem_r : {rem_r[30:0], 1'b0};
  assign qbit    = (rem_cur >= {1'b0, len});
  assign quo_nxt = {quo_r[14:0], qbit};
  assign clamp   = (quo_nxt[15]) ? 16'h7FFF : quo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mvna_pkg::U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_nxt == mvna_pkg::U_DONE);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvna_pkg::U_IDLE: if (start) state_nxt = mvna_pkg::U_NORM;
      mvna_pkg::U_NORM: begin
        if (m_r == '0) state_nxt = mvna_pkg::U_DONE;
        else if (m_r[50:30] == '0 && m_r[29]) state_nxt = mvna_pkg::U_SQ;
      end
      mvna_pkg::U_SQ:   if (cnt_r == 2'd3) state_nxt = mvna_pkg::U_SQRT;
      mvna_pkg::U_SQRT: if (bit_r == 63'd1) state_nxt = mvna_pkg::U_DIV;
      mvna_pkg::U_DIV:  if (dstep_r == 4'd15 && cnt_r == 2'd2) state_nxt = mvna_pkg::U_DONE;
      mvna_pkg::U_DONE: state_nxt = mvna_pkg::U_IDLE;
      default:          state_nxt = mvna_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mvna_pkg::U_IDLE: begin
        if (start) begin
          mag_r[0] <= mag_in[0];
          mag_r[1] <= mag_in[1];
          mag_r[2] <= mag_in[2];
          neg_r    <= {vz[50], vy[50], vx[50]};
          m_r      <= max_in;
          cnt_r    <= 2'd0;
          sum_r    <= '0;
        end
      end
      mvna_pkg::U_NORM: begin
        if (m_r == '0) begin
          q_r[0] <= '0;
          q_r[1] <= '0;
          q_r[2] <= '0;
        end else if (m_r[50:30] != '0) begin
          m_r      <= m_r >> 1;
          mag_r[0] <= mag_r[0] >> 1;
          mag_r[1] <= mag_r[1] >> 1;
          mag_r[2] <= mag_r[2] >> 1;
        end else if (!m_r[29]) begin
          m_r      <= m_r << 1;
          mag_r[0] <= mag_r[0] << 1;
          mag_r[1] <= mag_r[1] << 1;
          mag_r[2] <= mag_r[2] << 1;
        end
      end
      mvna_pkg::U_SQ: begin
        // each square is registered, then added to the sum in the next cycle
        if (cnt_r != 2'd3) prod_r <= sq_op * sq_op;
        if (cnt_r != 2'd0) sum_r <= sum_r + 62'(prod_r);
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          x_r   <= {1'b0, sum_r + 62'(prod_r)};
          res_r <= '0;
          bit_r <= 63'd1 << 62;
        end
      end
      mvna_pkg::U_SQRT: begin
        if (x_r >= trial) begin
          x_r   <= x_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r   <= bit_r >> 2;
        cnt_r   <= 2'd0;
        dstep_r <= 4'd0;
        rem_r   <= mag_r[0][31:0];
        quo_r   <= '0;
      end
      mvna_pkg::U_DIV: begin
        rem_r   <= qbit ? rem_cur - {1'b0, len} : rem_cur;
        quo_r   <= quo_nxt;
        dstep_r <= dstep_r + 4'd1;
        if (dstep_r == 4'd15) begin
          q_r[cnt_r] <= neg_r[cnt_r] ? -$signed(clamp) : $signed(clamp);
          cnt_r      <= cnt_r + 2'd1;
          quo_r      <= '0;
          rem_r      <= (cnt_r == 2'd0) ? mag_r[1][31:0] : mag_r[2][31:0];
        end
      end
      default: ;
    endcase
  end

  assign res.done = done_r;
  assign res.qx   = q_r[0];
  assign res.qy   = q_r[1];
  assign res.qz   = q_r[2];

endmodule

`default_nettype wire

@@ sv/mesh_vertex_normal_accumulate_top.sv @@
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulate_top
// Vertex position store and per-vertex face normal sums; triangles add their
// unit normal to each corner, reads return the normalized sum.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                       | tuser
// in_     | in  | index_a, index_b, index_c, pos_x/y/z     | kind
// out_    | out | vertex_index, normal_x, normal_y, normal_z | bad_index
// cfg_    | in  | vertex_count (write only)                | -
//
// Reads and triangles pass through the unit-vector stage: up to 29 normalizing
// shifts, the sum of squares, 32 square root steps and 16 division steps per
// component. A zero vector skips root and divide: a zero-sum read or a
// degenerate triangle. An out-of-range read returns a bad_index result without
// the unit; an out-of-range triangle is dropped. Corner updates are 3 serial
// read-modify-writes on the single-port sum memory. No clearing pass after
// reset. A finished read result waits in the output register; the next item
// is taken once the current one is through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mesh_vertex_normal_accumulate_top_defines.svh"

module mesh_vertex_normal_accumulate_top #(
  parameter int MAX_VERTICES = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // index_a[11:0], index_b[23:12], index_c[35:24], pos_x[59:36],
  // pos_y[83:60], pos_z[107:84], zero fill
  input  wire logic [111:0] in_tdata,
  // kind[1:0]
  input  wire logic [1:0]   in_tuser,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // vertex_index[11:0], normal_x[27:12], normal_y[43:28], normal_z[59:44],
  // zero fill
  output      logic [63:0]  out_tdata,
  // bad_index[0]
  output      logic [0:0]   out_tuser,
  input  wire logic         cfg_wr_en,
  input  wire logic [12:0]  cfg_wr_data
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  function automatic logic [AW-1:0] to_addr(input logic [11:0] idx);
    logic [16:0] ext;
    ext = {5'b0, idx};
    return ext[AW-1:0];
  endfunction

  function automatic logic [23:0] sat_add(input logic [23:0] s, input logic [15:0] q);
    logic [24:0] t;
    t = {s[23], s} + {{9{q[15]}}, q};
    if (t[24] != t[23]) return t[24] ? 24'h800000 : 24'h7FFFFF;
    return t[23:0];
  endfunction

  mvna_pkg::top_state_t state_r, state_nxt;

  logic [12:0] vcount_r;
  logic [11:0] idx_r [3];
  logic [1:0]  cnt_r;
  logic [2:0]  step_r;
  logic        bad_r;

  logic [71:0] pos_mem [MAX_VERTICES];
  logic [71:0] sum_mem [MAX_VERTICES];
  logic [71:0] pos_q_r, sum_q_r;
  logic [71:0] pa_r, pb_r, pc_r;

  logic signed [24:0] e1_r [3];
  logic signed [24:0] e2_r [3];
  logic signed [49:0] prod_r;
  logic signed [50:0] cr_r [3];

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_bad_r;

  logic [11:0] in_ia, in_ib, in_ic;
  mvna_pkg::kind_t in_kind;
  logic        in_acc;
  logic        ok_a, ok_b, ok_c;
  logic [AW-1:0] mem_addr;
  logic        pos_we, sum_we;
  logic [71:0] sum_wdata;
  logic signed [24:0] mul_a, mul_b;
  logic        unit_start;
  logic signed [50:0] uvx, uvy, uvz;
  mvna_pkg::unit_res_t ures;
  logic        out_load;

  assign in_ia   = in_tdata[11:0];
  assign in_ib   = in_tdata[23:12];
  assign in_ic   = in_tdata[35:24];
  assign in_kind = mvna_pkg::kind_t'(in_tuser);
  assign in_tready = (state_r == mvna_pkg::ST_IDLE);
  assign in_acc  = in_tvalid && in_tready;

  assign ok_a = ({1'b0, in_ia} < vcount_r) && (32'(in_ia) < MAX_VERTICES);
  assign ok_b = ({1'b0, in_ib} < vcount_r) && (32'(in_ib) < MAX_VERTICES);
  assign ok_c = ({1'b0, in_ic} < vcount_r) && (32'(in_ic) < MAX_VERTICES);

  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= '0;
    else if (cfg_wr_en) vcount_r <= cfg_wr_data;
  end

  // memory port control
  always_comb begin
    mem_addr  = to_addr(idx_r[0]);
    pos_we    = 1'b0;
    sum_we    = 1'b0;
    sum_wdata = '0;
    unique case (state_r)
      mvna_pkg::ST_IDLE: begin
        mem_addr = to_addr(in_ia);
        if (in_acc && in_kind == mvna_pkg::KIND_LOAD && 32'(in_ia) < MAX_VERTICES) begin
          pos_we = 1'b1;
          sum_we = 1'b1;
        end
      end
      mvna_pkg::ST_RD_A:   mem_addr = to_addr(idx_r[0]);
      mvna_pkg::ST_RD_B:   mem_addr = to_addr(idx_r[1]);
      mvna_pkg::ST_RD_C:   mem_addr = to_addr(idx_r[2]);
      mvna_pkg::ST_ACC_RD: mem_addr = to_addr(idx_r[cnt_r]);
      mvna_pkg::ST_ACC_WR: begin
        mem_addr  = to_addr(idx_r[cnt_r]);
        sum_we    = 1'b1;
        sum_wdata = {sat_add(sum_q_r[71:48], ures.qz),
                     sat_add(sum_q_r[47:24], ures.qy),
                     sat_add(sum_q_r[23:0],  ures.qx)};
      end
      default: mem_addr = to_addr(idx_r[0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[mem_addr] <= in_tdata[107:36];
    pos_q_r <= pos_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[mem_addr] <= sum_wdata;
    sum_q_r <= sum_mem[mem_addr];
  end

  // cross product operands, one product per cycle
  always_comb begin
    case (step_r)
      3'd0:    begin mul_a = e1_r[1]; mul_b = e2_r[2]; end
      3'd1:    begin mul_a = e1_r[2]; mul_b = e2_r[1]; end
      3'd2:    begin mul_a = e1_r[2]; mul_b = e2_r[0]; end
      3'd3:    begin mul_a = e1_r[0]; mul_b = e2_r[2]; end
      3'd4:    begin mul_a = e1_r[0]; mul_b = e2_r[1]; end
      default: begin mul_a = e1_r[1]; mul_b = e2_r[0]; end
    endcase
  end

  // cr_r[2] takes its last difference at step 6, so the unit starts at step 7
  assign unit_start = (state_r == mvna_pkg::ST_CROSS && step_r == 3'd7) ||
                      (state_r == mvna_pkg::ST_R_CAP);
  assign uvx = (state_r == mvna_pkg::ST_R_CAP) ? 51'($signed(sum_q_r[23:0]))  : cr_r[0];
  assign uvy = (state_r == mvna_pkg::ST_R_CAP) ? 51'($signed(sum_q_r[47:24])) : cr_r[1];
  assign uvz = (state_r == mvna_pkg::ST_R_CAP) ? 51'($signed(sum_q_r[71:48])) : cr_r[2];

  mvna_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .vx    (uvx),
    .vy    (uvy),
    .vz    (uvz),
    .res   (ures)
  );

  assign out_load = (state_r == mvna_pkg::ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvna_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == mvna_pkg::KIND_TRI && ok_a && ok_b && ok_c)
            state_nxt = mvna_pkg::ST_RD_A;
          else if (in_kind == mvna_pkg::KIND_READ)
            state_nxt = ok_a ? mvna_pkg::ST_R_RD : mvna_pkg::ST_DONE;
        end
      end
      mvna_pkg::ST_RD_A:   state_nxt = mvna_pkg::ST_RD_B;
      mvna_pkg::ST_RD_B:   state_nxt = mvna_pkg::ST_RD_C;
      mvna_pkg::ST_RD_C:   state_nxt = mvna_pkg::ST_CAP_C;
      mvna_pkg::ST_CAP_C:  state_nxt = mvna_pkg::ST_EDGE;
      mvna_pkg::ST_EDGE:   state_nxt = mvna_pkg::ST_CROSS;
      mvna_pkg::ST_CROSS:  if (step_r == 3'd7) state_nxt = mvna_pkg::ST_TUNIT;
      mvna_pkg::ST_TUNIT:  if (ures.done) state_nxt = mvna_pkg::ST_ACC_RD;
      mvna_pkg::ST_ACC_RD: state_nxt = mvna_pkg::ST_ACC_WR;
      mvna_pkg::ST_ACC_WR:
        state_nxt = (cnt_r == 2'd2) ? mvna_pkg::ST_IDLE : mvna_pkg::ST_ACC_RD;
      mvna_pkg::ST_R_RD:   state_nxt = mvna_pkg::ST_R_CAP;
      mvna_pkg::ST_R_CAP:  state_nxt = mvna_pkg::ST_RUNIT;
      mvna_pkg::ST_RUNIT:  if (ures.done) state_nxt = mvna_pkg::ST_DONE;
      mvna_pkg::ST_DONE:   if (out_load) state_nxt = mvna_pkg::ST_IDLE;
      default:             state_nxt = mvna_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mvna_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mvna_pkg::ST_IDLE: begin
        idx_r[0] <= in_ia;
        idx_r[1] <= in_ib;
        idx_r[2] <= in_ic;
        bad_r    <= !ok_a;
        cnt_r    <= 2'd0;
        step_r   <= 3'd0;
      end
      mvna_pkg::ST_RD_B:  pa_r <= pos_q_r;
      mvna_pkg::ST_RD_C:  pb_r <= pos_q_r;
      mvna_pkg::ST_CAP_C: pc_r <= pos_q_r;
      mvna_pkg::ST_EDGE: begin
        e1_r[0] <= 25'($signed(pb_r[23:0]))  - 25'($signed(pa_r[23:0]));
        e1_r[1] <= 25'($signed(pb_r[47:24])) - 25'($signed(pa_r[47:24]));
        e1_r[2] <= 25'($signed(pb_r[71:48])) - 25'($signed(pa_r[71:48]));
        e2_r[0] <= 25'($signed(pc_r[23:0]))  - 25'($signed(pa_r[23:0]));
        e2_r[1] <= 25'($signed(pc_r[47:24])) - 25'($signed(pa_r[47:24]));
        e2_r[2] <= 25'($signed(pc_r[71:48])) - 25'($signed(pa_r[71:48]));
      end
      mvna_pkg::ST_CROSS: begin
        if (step_r < 3'd6) prod_r <= mul_a * mul_b;
        // odd steps open a component, even steps subtract the second term
        case (step_r)
          3'd1:    cr_r[0] <= 51'(prod_r);
          3'd2:    cr_r[0] <= cr_r[0] - 51'(prod_r);
          3'd3:    cr_r[1] <= 51'(prod_r);
          3'd4:    cr_r[1] <= cr_r[1] - 51'(prod_r);
          3'd5:    cr_r[2] <= 51'(prod_r);
          3'd6:    cr_r[2] <= cr_r[2] - 51'(prod_r);
          default: ;
        endcase
        step_r <= step_r + 3'd1;
      end
      mvna_pkg::ST_ACC_WR: cnt_r <= cnt_r + 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bad_r  <= bad_r;
      out_data_r <= bad_r ? {52'b0, idx_r[0]} :
                    {4'b0, ures.qz, ures.qy, ures.qx, idx_r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;

  `MVNA_ASSERT_IMP(a_unit_done_wait, clk, rst_n, ures.done,
    state_r == mvna_pkg::ST_TUNIT || state_r == mvna_pkg::ST_RUNIT)
  `MVNA_ASSERT_IMP(a_bad_zero, clk, rst_n, out_tvalid && out_tuser[0],
    out_tdata[59:12] == 48'd0)
  `MVNA_ASSERT_IMP(a_sum_write_place, clk, rst_n, sum_we,
    state_r == mvna_pkg::ST_IDLE || state_r == mvna_pkg::ST_ACC_WR)
  `MVNA_ASSERT_NXT(a_read_busy, clk, rst_n,
    in_acc && in_kind == mvna_pkg::KIND_READ, state_r != mvna_pkg::ST_IDLE)

endmodule

`default_nettype wire

@@ tb/sv/mesh_vertex_normal_accumulate_top_tb.sv @@
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulate_top_tb
// Loads vertex positions, sends triangles and normal reads across several
// vertex_count settings, and checks each read result against a behavioral
// predictor of the face normal sums. Every index used is loaded first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mesh_vertex_normal_accumulate_top_tb;

  typedef struct {
    mvna_pkg::kind_t    kind;
    logic [11:0]        ia, ib, ic;
    logic signed [23:0] px, py, pz;
  } vtx_item_t;

  typedef struct packed {
    logic [11:0]        vi;
    logic signed [15:0] nx, ny, nz;
    logic               bad;
  } normal_res_t;

  typedef struct packed {
    logic signed [15:0] x, y, z;
  } unit_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [12:0]  cfg_wr_data = '0;

  vtx_item_t   pend_items[$];
  normal_res_t normal_q[$];
  int          errors = 0;
  bit          calm = 1'b0;
  int unsigned vcount = 0;
  int          pos_x_mem[4096], pos_y_mem[4096], pos_z_mem[4096];
  int          sum_x_mem[4096], sum_y_mem[4096], sum_z_mem[4096];
  logic [11:0] pool[$];

  always #4 clk = ~clk;

  mesh_vertex_normal_accumulate_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  function automatic unit_t scale_unit(longint vx, longint vy, longint vz);
    longint          vv[3];
    longint unsigned mg[3];
    bit              ng[3];
    longint unsigned m, s, x, r, bt, c;
    unit_t           o;
    vv[0] = vx; vv[1] = vy; vv[2] = vz;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = vv[i] < 0;
      mg[i] = ng[i] ? -vv[i] : vv[i];
      if (mg[i] > m) m = mg[i];
    end
    o = '0;
    if (m == 0) return o;
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mg[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mg[i] <<= 1;
    end
    s = 0;
    for (int i = 0; i < 3; i++) s += mg[i] * mg[i];
    // bitwise floor square root
    x = s; r = 0; bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      c = (mg[i] << 15) / r;
      if (c > 32767) c = 32767;
      mg[i] = ng[i] ? -c : c;
    end
    o.x = mg[0][15:0]; o.y = mg[1][15:0]; o.z = mg[2][15:0];
    return o;
  endfunction

  function automatic int sat_acc(int a, int b);
    int s;
    s = a + b;
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    return s;
  endfunction

  function automatic bit in_use(logic [11:0] idx);
    return idx < vcount;
  endfunction

  // advance the normal sums for one accepted item
  task automatic predict_normals(vtx_item_t it);
    longint      e1x, e1y, e1z, e2x, e2y, e2z;
    unit_t       u;
    logic [11:0] cn[3];
    normal_res_t r;
    case (it.kind)
      mvna_pkg::KIND_LOAD: begin
        pos_x_mem[it.ia] = it.px; pos_y_mem[it.ia] = it.py; pos_z_mem[it.ia] = it.pz;
        sum_x_mem[it.ia] = 0; sum_y_mem[it.ia] = 0; sum_z_mem[it.ia] = 0;
      end
      mvna_pkg::KIND_TRI: begin
        if (in_use(it.ia) && in_use(it.ib) && in_use(it.ic)) begin
          e1x = pos_x_mem[it.ib] - pos_x_mem[it.ia];
          e1y = pos_y_mem[it.ib] - pos_y_mem[it.ia];
          e1z = pos_z_mem[it.ib] - pos_z_mem[it.ia];
          e2x = pos_x_mem[it.ic] - pos_x_mem[it.ia];
          e2y = pos_y_mem[it.ic] - pos_y_mem[it.ia];
          e2z = pos_z_mem[it.ic] - pos_z_mem[it.ia];
          u = scale_unit(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
                         e1x * e2y - e1y * e2x);
          cn[0] = it.ia; cn[1] = it.ib; cn[2] = it.ic;
          for (int k = 0; k < 3; k++) begin
            sum_x_mem[cn[k]] = sat_acc(sum_x_mem[cn[k]], u.x);
            sum_y_mem[cn[k]] = sat_acc(sum_y_mem[cn[k]], u.y);
            sum_z_mem[cn[k]] = sat_acc(sum_z_mem[cn[k]], u.z);
          end
        end
      end
      mvna_pkg::KIND_READ: begin
        r = '0;
        r.vi = it.ia;
        r.bad = 1'b1;
        if (in_use(it.ia)) begin
          u = scale_unit(sum_x_mem[it.ia], sum_y_mem[it.ia], sum_z_mem[it.ia]);
          r.nx = u.x; r.ny = u.y; r.nz = u.z;
          r.bad = 1'b0;
        end
        normal_q = {normal_q, r};
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    vtx_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pend_items.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
        it = pend_items.pop_front();
        in_tdata  <= {4'b0, it.pz, it.py, it.px, it.ic, it.ib, it.ia};
        in_tuser  <= it.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= calm || $urandom_range(99) >= 15;
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    vtx_item_t   it;
    normal_res_t got, want;
    if (rst_n && in_tvalid && in_tready) begin
      it.kind = mvna_pkg::kind_t'(in_tuser);
      {it.pz, it.py, it.px, it.ic, it.ib, it.ia} = in_tdata[107:0];
      predict_normals(it);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[11:0], out_tdata[27:12], out_tdata[43:28], out_tdata[59:44],
             out_tuser[0]};
      if (normal_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer %h", got);
      end else begin
        want = normal_q.pop_front();
        if (got.vi !== want.vi || got.nx !== want.nx || got.ny !== want.ny ||
            got.nz !== want.nz || got.bad !== want.bad) begin
          errors++;
          if (errors <= 10)
            $display({"normal mismatch: exp vi=%0d n=(%0d,%0d,%0d) bad=%0d",
                      " got vi=%0d n=(%0d,%0d,%0d) bad=%0d"},
                     want.vi, want.nx, want.ny, want.nz, want.bad,
                     got.vi, got.nx, got.ny, got.nz, got.bad);
        end
      end
    end
  end

  task automatic send(mvna_pkg::kind_t k, logic [11:0] a, logic [11:0] b, logic [11:0] c,
                      int x = 0, int y = 0, int z = 0);
    vtx_item_t it;
    it.kind = k; it.ia = a; it.ib = b; it.ic = c;
    it.px = x[23:0]; it.py = y[23:0]; it.pz = z[23:0];
    pend_items = {pend_items, it};
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pend_items.size() != 0 || in_tvalid || normal_q.size() != 0);
    repeat (200) @(posedge clk);  // triangles leave no result to wait on
  endtask

  task automatic set_vertex_count(int unsigned v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[12:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vcount = v;
  endtask

  function automatic logic [11:0] pick();
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  function automatic int rpos();
    return $signed($urandom_range(24'hFFFFFF, 0) << 8) >>> 8;
  endfunction

  initial begin
    int unsigned counts[5] = '{4096, 3, 17, 4095, 1};
    int r;
    for (int i = 0; i < 16; i++) pool = {pool, 12'(i)};
    pool = {pool, 12'd2048, 12'd4094, 12'd4095};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // every used index is loaded, ignoring vertex_count
    foreach (pool[i]) send(mvna_pkg::KIND_LOAD, pool[i], 0, 0, rpos(), rpos(), rpos());
    send(mvna_pkg::KIND_READ, 5, 0, 0);
    send(mvna_pkg::KIND_TRI, 0, 1, 2);
    send(mvna_pkg::KIND_NOP, 12'hFFF, 12'hFFF, 12'hFFF, -1, -1, -1);

    set_vertex_count(4096);
    send(mvna_pkg::KIND_LOAD, 0, 0, 0, 8388607, -8388608, 8388607);
    send(mvna_pkg::KIND_LOAD, 1, 0, 0, -8388608, 8388607, -8388608);
    send(mvna_pkg::KIND_TRI, 0, 1, 2);
    send(mvna_pkg::KIND_TRI, 0, 0, 1);  // degenerate
    send(mvna_pkg::KIND_READ, 0, 0, 0);
    send(mvna_pkg::KIND_READ, 1, 0, 0);
    send(mvna_pkg::KIND_READ, 4095, 0, 0);  // zero sum
    send(mvna_pkg::KIND_TRI, 4095, 4094, 2048);
    send(mvna_pkg::KIND_READ, 4095, 0, 0);
    send(mvna_pkg::KIND_READ, 2048, 0, 0);
    // unit normal along +x, repeated until the sums clip
    send(mvna_pkg::KIND_LOAD, 3, 0, 0, 0, 0, 0);
    send(mvna_pkg::KIND_LOAD, 4, 0, 0, 0, 65536, 0);
    send(mvna_pkg::KIND_LOAD, 5, 0, 0, 0, 0, 65536);
    drain();
    calm = 1'b1;
    repeat (260) send(mvna_pkg::KIND_TRI, 3, 4, 5);
    send(mvna_pkg::KIND_READ, 3, 0, 0);
    send(mvna_pkg::KIND_READ, 5, 0, 0);
    drain();
    calm = 1'b0;

    foreach (counts[p]) begin
      set_vertex_count(counts[p]);
      repeat (80) begin
        r = $urandom_range(99);
        if (r < 10) send(mvna_pkg::KIND_LOAD, pick(), 0, 0, rpos(), rpos(), rpos());
        else if (r < 60) send(mvna_pkg::KIND_TRI, pick(), pick(), pick());
        else if (r < 92) send(mvna_pkg::KIND_READ, pick(), 0, 0);
        else send(mvna_pkg::KIND_NOP, pick(), pick(), pick(), rpos(), rpos(), rpos());
      end
    end
    set_vertex_count(0);
    send(mvna_pkg::KIND_READ, 0, 0, 0);
    drain();

    if (errors == 0 && normal_q.size() == 0) begin
      $display("mesh_vertex_normal_accumulate_top_tb passed");
    end else begin
      $display("mesh_vertex_normal_accumulate_top_tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("mesh_vertex_normal_accumulate_top_tb failed");
    $finish;
  end

endmodule
